// ----- rtl/mtt_pkg.sv -----
`default_nettype none

package mtt_pkg;

	// Register map, one 32-bit word per register
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_ENABLE_MASK    = 2'd0,
		REG_CURRENT_SCREEN = 2'd1,
		REG_HAS_SUBS       = 2'd2
	} reg_idx_t;

	// Consoles that exist; current_screen at or above this disables tracking
	localparam logic [3:0] NUM_SCREENS = 4'd8;

	// Status byte layout
	localparam int STAT_OVF_X  = 6;
	localparam int STAT_OVF_Y  = 7;
	localparam int STAT_SIGN_X = 4;
	localparam int STAT_SIGN_Y = 5;

	localparam logic signed [1:0] WHEEL_UP   = 2'sb01;
	localparam logic signed [1:0] WHEEL_DOWN = 2'sb11;
	localparam logic signed [1:0] WHEEL_NONE = 2'sb00;

	typedef struct packed {
		logic [7:0] enable_mask;
		logic [2:0] current_screen;
		logic       has_subscribers;
	} cfg_t;

	// Per-packet decode result carried down the pipe
	typedef struct packed {
		logic        dropped;
		logic        update;
		logic        event_valid;
		logic [2:0]  buttons;
		logic [1:0]  wheel;
		logic [2:0]  console;
	} flags_t;

endpackage

`default_nettype wire

// ----- rtl/mtt_cfg_regs.sv -----
`default_nettype none

module mtt_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mtt_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mtt_pkg::DATA_W-1:0]  pwdata,
	output logic      [mtt_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output mtt_pkg::cfg_t                    cfg
);

	mtt_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				mtt_pkg::REG_ENABLE_MASK: begin
					cfg_q.enable_mask <= pwdata[7:0];
				end
				mtt_pkg::REG_CURRENT_SCREEN: begin
					cfg_q.current_screen <= pwdata[2:0];
				end
				mtt_pkg::REG_HAS_SUBS: begin
					cfg_q.has_subscribers <= pwdata[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mtt_pkg::REG_ENABLE_MASK:    prdata = {24'd0, cfg_q.enable_mask};
			mtt_pkg::REG_CURRENT_SCREEN: prdata = {29'd0, cfg_q.current_screen};
			mtt_pkg::REG_HAS_SUBS:       prdata = {31'd0, cfg_q.has_subscribers};
			default:                     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/mtt_pos_stage.sv -----
`default_nettype none

module mtt_pos_stage #(
	parameter int MAX_X = 639,
	parameter int MAX_Y = 199,
	parameter int PW    = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mtt_pkg::cfg_t  cfg,
	input  wire logic           pkt_valid,
	output logic                pkt_ready,
	input  wire logic [7:0]     status_byte,
	input  wire logic [7:0]     delta_x_byte,
	input  wire logic [7:0]     delta_y_byte,
	input  wire logic [7:0]     wheel_byte,
	input  wire logic           s1_ready,
	output logic                valid_s1,
	output mtt_pkg::flags_t     flags_s1,
	output logic [PW-1:0]       px_s1,
	output logic [PW-1:0]       py_s1
);

	localparam int SW = ((PW > 10) ? PW : 10) + 2;
	localparam logic signed [SW-1:0] MAXX_S = SW'(MAX_X);
	localparam logic signed [SW-1:0] MAXY_S = SW'(MAX_Y);

	logic [PW-1:0]         pix_x_q;
	logic [PW-1:0]         pix_y_q;
	logic                  accept;
	logic                  enabled;
	logic                  overflow;
	logic                  update;
	logic signed [SW-1:0]  dx_ext;
	logic signed [SW-1:0]  dy_ext;
	logic signed [SW-1:0]  sum_x;
	logic signed [SW-1:0]  sum_y;
	logic [PW-1:0]         nx;
	logic [PW-1:0]         ny;
	logic [2:0]            buttons;
	logic [1:0]            wheel;
	mtt_pkg::flags_t       flags_d;

	assign pkt_ready = !valid_s1 || s1_ready;
	assign accept    = pkt_valid && pkt_ready;

	assign enabled  = ({1'b0, cfg.current_screen} < mtt_pkg::NUM_SCREENS)
	                  && cfg.enable_mask[cfg.current_screen];
	assign overflow = status_byte[mtt_pkg::STAT_OVF_X] || status_byte[mtt_pkg::STAT_OVF_Y];
	assign update   = enabled && !overflow;

	always_comb begin
		dx_ext = {{(SW-8){status_byte[mtt_pkg::STAT_SIGN_X]}}, delta_x_byte};
		dy_ext = {{(SW-8){status_byte[mtt_pkg::STAT_SIGN_Y]}}, delta_y_byte};
		// Y is upward positive on the wire, downward on screen
		sum_x  = $signed({{(SW-PW){1'b0}}, pix_x_q}) + dx_ext;
		sum_y  = $signed({{(SW-PW){1'b0}}, pix_y_q}) - dy_ext;

		if (sum_x < 0) begin
			nx = '0;
		end else if (sum_x >= MAXX_S) begin
			nx = PW'(MAX_X);
		end else begin
			nx = sum_x[PW-1:0];
		end

		if (sum_y < 0) begin
			ny = '0;
		end else if (sum_y >= MAXY_S) begin
			ny = PW'(MAX_Y);
		end else begin
			ny = sum_y[PW-1:0];
		end
	end

	always_comb begin
		buttons = status_byte[2:0];
		if (wheel_byte[3:0] == 4'd0) begin
			wheel = mtt_pkg::WHEEL_NONE;
		end else if (wheel_byte[3]) begin
			wheel = mtt_pkg::WHEEL_DOWN;
		end else begin
			wheel = mtt_pkg::WHEEL_UP;
		end

		flags_d             = '0;
		flags_d.console     = cfg.current_screen;
		flags_d.dropped     = enabled && overflow;
		flags_d.update      = update;
		if (update) begin
			flags_d.buttons     = buttons;
			flags_d.wheel       = wheel;
			flags_d.event_valid = ((buttons != 3'd0) || (wheel != mtt_pkg::WHEEL_NONE))
			                      && cfg.has_subscribers;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pix_x_q  <= PW'(MAX_X);
			pix_y_q  <= PW'(MAX_Y);
		end else begin
			if (pkt_ready) begin
				valid_s1 <= pkt_valid;
			end
			if (accept && update) begin
				pix_x_q <= nx;
				pix_y_q <= ny;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags_d;
			px_s1    <= nx;
			py_s1    <= ny;
		end
	end

	a_pix_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_x_q <= PW'(MAX_X))
		else $error("pixel X beyond its clamp limit");

	a_pix_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_y_q <= PW'(MAX_Y))
		else $error("pixel Y beyond its clamp limit");

endmodule

`default_nettype wire

// ----- rtl/mtt_cell_stage.sv -----
`default_nettype none

module mtt_cell_stage #(
	parameter int PIXELS_PER_CELL = 8,
	parameter int MAX_X           = 639,
	parameter int PW              = 10,
	parameter int CW              = 7,
	parameter int RW              = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_s1,
	output logic             s1_ready,
	input  wire mtt_pkg::flags_t flags_s1,
	input  wire logic [PW-1:0] px_s1,
	input  wire logic [PW-1:0] py_s1,
	input  wire logic        s2_ready,
	output logic             valid_s2,
	output mtt_pkg::flags_t  flags_s2,
	output logic [CW-1:0]    col_s2,
	output logic [RW-1:0]    row_s2
);

	// Divide by reciprocal: exact for any pixel below 2**PW and divisor up to 64
	localparam int SH     = PW + 7;
	localparam longint RECIP = ((longint'(1) << SH) + PIXELS_PER_CELL - 1) / PIXELS_PER_CELL;
	localparam int MW     = $clog2(RECIP + 1);
	localparam int PRW    = PW + MW;
	localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
	localparam logic [CW-1:0] COL_LIM = CW'(MAX_X / PIXELS_PER_CELL);

	logic [PRW-1:0] prod_x;
	logic [PRW-1:0] prod_y;
	logic [PW-1:0]  qx;
	logic [PW-1:0]  qy;
	logic           take;

	assign s1_ready = !valid_s2 || s2_ready;
	assign take     = valid_s1 && s1_ready;

	assign prod_x = PRW'(px_s1) * PRW'(RECIP_C);
	assign prod_y = PRW'(py_s1) * PRW'(RECIP_C);
	assign qx     = PW'(prod_x >> SH);
	assign qy     = PW'(prod_y >> SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flags_s2 <= flags_s1;
			col_s2   <= CW'(qx);
			row_s2   <= RW'(qy);
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && flags_s2.update |-> col_s2 <= COL_LIM)
		else $error("text column beyond the last pixel cell");

endmodule

`default_nettype wire

// ----- rtl/mtt_out_stage.sv -----
`default_nettype none

module mtt_out_stage #(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int CW   = 7,
	parameter int RW   = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s2,
	output logic                   s2_ready,
	input  wire mtt_pkg::flags_t   flags_s2,
	input  wire logic [CW-1:0]     col_s2,
	input  wire logic [RW-1:0]     row_s2,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic                   packet_dropped,
	output logic                   event_valid,
	output logic [2:0]             button_bits,
	output logic signed [1:0]      wheel_step,
	output logic [6:0]             cell_column,
	output logic [4:0]             cell_line,
	output logic [2:0]             console_index,
	output logic                   cursor_moved,
	output logic [12:0]            old_cell_offset,
	output logic [12:0]            new_cell_offset
);

	localparam logic [11:0] COLS_C  = 12'(COLS);
	localparam logic [12:0] OFF_RST = 13'((((COLS + COLS * ROWS) % 4096) * 2));

	logic [CW-1:0] shown_col_q;
	logic [RW-1:0] shown_row_q;
	logic [12:0]   shown_off_q;
	logic          take;
	logic [11:0]   lin;
	logic [12:0]   new_off;
	logic          moved;

	assign s2_ready = !res_valid || res_ready;
	assign take     = valid_s2 && s2_ready;

	// Byte offset of a cell, two bytes per cell, wrapped to 13 bits
	assign lin     = 12'(col_s2) + COLS_C * 12'(row_s2);
	assign new_off = {lin, 1'b0};
	assign moved   = (col_s2 != shown_col_q) || (row_s2 != shown_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid   <= 1'b0;
			shown_col_q <= CW'(COLS);
			shown_row_q <= RW'(ROWS);
			shown_off_q <= OFF_RST;
		end else begin
			if (s2_ready) begin
				res_valid <= valid_s2;
			end
			if (take && flags_s2.update) begin
				shown_col_q <= col_s2;
				shown_row_q <= row_s2;
				shown_off_q <= new_off;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			packet_dropped  <= flags_s2.dropped;
			event_valid     <= flags_s2.event_valid;
			button_bits     <= flags_s2.buttons;
			wheel_step      <= flags_s2.wheel;
			console_index   <= flags_s2.console;
			old_cell_offset <= shown_off_q;
			if (flags_s2.update) begin
				cell_column     <= 7'(col_s2);
				cell_line       <= 5'(row_s2);
				cursor_moved    <= moved;
				new_cell_offset <= new_off;
			end else begin
				cell_column     <= 7'(shown_col_q);
				cell_line       <= 5'(shown_row_q);
				cursor_moved    <= 1'b0;
				new_cell_offset <= shown_off_q;
			end
		end
	end

	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && packet_dropped |-> !cursor_moved && !event_valid)
		else $error("dropped packet reported a move or an event");

	a_still_same_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !cursor_moved |-> old_cell_offset == new_cell_offset)
		else $error("cursor did not move but offsets differ");

endmodule

`default_nettype wire

// ----- rtl/ps2_mouse_text_cursor_tracker_top.sv -----
`default_nettype none

// PS/2 mouse cursor tracker for a text console. Each transfer on the packet
// channel carries one mouse packet (status, X delta, Y delta, wheel byte) and
// produces exactly one result transfer: overflow drop flag, button/wheel
// event, the text cell under the cursor and the byte offsets of the cell shown
// before and after the packet. A packet is acted on only when the enable bit
// of the console now shown is set; otherwise the result repeats the cell shown.
// A packet can be taken every clock cycle while results are taken; a result
// passes the clamp, cell divide and offset/output registers in turn and
// stays until taken, while the pipe keeps filling behind it.
// Configuration goes through the APB port at byte addresses 0 (enable mask),
// 4 (current screen) and 8 (subscriber flag); write it only when no packet is
// in flight.

module ps2_mouse_text_cursor_tracker_top #(
	parameter int COLS            = 80,
	parameter int ROWS            = 25,
	parameter int PIXELS_PER_CELL = 8,
	parameter int MAX_X           = 639,
	parameter int MAX_Y           = 199
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// APB configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mtt_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mtt_pkg::DATA_W-1:0]  pwdata,
	output logic      [mtt_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	// packet channel
	input  wire logic                        pkt_valid,
	output logic                             pkt_ready,
	input  wire logic [7:0]                  status_byte,
	input  wire logic [7:0]                  delta_x_byte,
	input  wire logic [7:0]                  delta_y_byte,
	input  wire logic [7:0]                  wheel_byte,
	// result channel
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic                             packet_dropped,
	output logic                             event_valid,
	output logic [2:0]                       button_bits,
	output logic signed [1:0]                wheel_step,
	output logic [6:0]                       cell_column,
	output logic [4:0]                       cell_line,
	output logic [2:0]                       console_index,
	output logic                             cursor_moved,
	output logic [12:0]                      old_cell_offset,
	output logic [12:0]                      new_cell_offset
);

	// Pixel width covers the larger clamp limit
	localparam int PW      = $clog2(((MAX_X > MAX_Y) ? MAX_X : MAX_Y) + 1);
	// Cell widths cover both the last reachable cell and the off-screen reset cell
	localparam int COL_TOP = (COLS > MAX_X / PIXELS_PER_CELL) ? COLS : MAX_X / PIXELS_PER_CELL;
	localparam int ROW_TOP = (ROWS > MAX_Y / PIXELS_PER_CELL) ? ROWS : MAX_Y / PIXELS_PER_CELL;
	localparam int CW      = $clog2(COL_TOP + 1);
	localparam int RW      = $clog2(ROW_TOP + 1);

	mtt_pkg::cfg_t   cfg;
	logic            valid_s1;
	logic            s1_ready;
	mtt_pkg::flags_t flags_s1;
	logic [PW-1:0]   px_s1;
	logic [PW-1:0]   py_s1;
	logic            valid_s2;
	logic            s2_ready;
	mtt_pkg::flags_t flags_s2;
	logic [CW-1:0]   col_s2;
	logic [RW-1:0]   row_s2;

	// Register file; its outputs are sampled when a packet is taken
	mtt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1: decode the packet, advance and clamp the pixel position.
	// The position register closes its loop inside this stage, so a packet
	// can follow in the very next cycle.
	mtt_pos_stage #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.PW    (PW)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pkt_valid    (pkt_valid),
		.pkt_ready    (pkt_ready),
		.status_byte  (status_byte),
		.delta_x_byte (delta_x_byte),
		.delta_y_byte (delta_y_byte),
		.wheel_byte   (wheel_byte),
		.s1_ready     (s1_ready),
		.valid_s1     (valid_s1),
		.flags_s1     (flags_s1),
		.px_s1        (px_s1),
		.py_s1        (py_s1)
	);

	// Stage 2: pixel to text cell, one reciprocal multiply per axis
	mtt_cell_stage #(
		.PIXELS_PER_CELL (PIXELS_PER_CELL),
		.MAX_X           (MAX_X),
		.PW              (PW),
		.CW              (CW),
		.RW              (RW)
	) u_cell (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.s1_ready (s1_ready),
		.flags_s1 (flags_s1),
		.px_s1    (px_s1),
		.py_s1    (py_s1),
		.s2_ready (s2_ready),
		.valid_s2 (valid_s2),
		.flags_s2 (flags_s2),
		.col_s2   (col_s2),
		.row_s2   (row_s2)
	);

	// Stage 3: compare with the shown cell, form offsets, hold the result
	// in the output register until the result transfer completes
	mtt_out_stage #(
		.COLS (COLS),
		.ROWS (ROWS),
		.CW   (CW),
		.RW   (RW)
	) u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s2        (valid_s2),
		.s2_ready        (s2_ready),
		.flags_s2        (flags_s2),
		.col_s2          (col_s2),
		.row_s2          (row_s2),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.packet_dropped  (packet_dropped),
		.event_valid     (event_valid),
		.button_bits     (button_bits),
		.wheel_step      (wheel_step),
		.cell_column     (cell_column),
		.cell_line       (cell_line),
		.console_index   (console_index),
		.cursor_moved    (cursor_moved),
		.old_cell_offset (old_cell_offset),
		.new_cell_offset (new_cell_offset)
	);

endmodule

`default_nettype wire

// ----- tb/tb_ps2_mouse_text_cursor_tracker_top.sv -----
module tb_ps2_mouse_text_cursor_tracker_top;

	// Geometry of the text screen; must match the block's default parameters
	localparam int COLS        = 80;
	localparam int ROWS        = 25;
	localparam int CELL_PX     = 8;
	localparam int MAX_X       = 639;
	localparam int MAX_Y       = 199;

	// APB widths of the block
	localparam int ADDR_W      = mtt_pkg::ADDR_W;
	localparam int DATA_W      = mtt_pkg::DATA_W;

	// Run shape
	localparam int PHASES      = 12;
	localparam int PHASE_PKTS  = 119;
	localparam int LONG_HOLD   = 80;
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_N       = 18;
	localparam int SHOW_MAX    = 10;

	// One result transfer, fields in port order
	typedef struct packed {
		logic        dropped;
		logic        evt;
		logic [2:0]  btn;
		logic [1:0]  whl;
		logic [6:0]  col;
		logic [4:0]  row;
		logic [2:0]  cons;
		logic        moved;
		logic [12:0] old_off;
		logic [12:0] new_off;
	} cursor_report_t;

	// One line of the directed walk: optional register update, the packet, and
	// a hand-written report where the answer is obvious
	typedef struct {
		logic           reconf;
		logic [7:0]     mask;
		logic [2:0]     scr;
		logic           subs;
		logic [7:0]     st;
		logic [7:0]     dx;
		logic [7:0]     dy;
		logic [7:0]     wh;
		logic           typed;
		cursor_report_t want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                pkt_valid;
	logic                pkt_ready;
	logic [7:0]          status_byte;
	logic [7:0]          delta_x_byte;
	logic [7:0]          delta_y_byte;
	logic [7:0]          wheel_byte;
	logic                res_valid;
	logic                res_ready;
	logic                packet_dropped;
	logic                event_valid;
	logic [2:0]          button_bits;
	logic signed [1:0]   wheel_step;
	logic [6:0]          cell_column;
	logic [4:0]          cell_line;
	logic [2:0]          console_index;
	logic                cursor_moved;
	logic [12:0]         old_cell_offset;
	logic [12:0]         new_cell_offset;

	// Predictor copy of the registers and of the cursor state
	logic [7:0]          enable_mask  = 8'h00;
	logic [2:0]          view_console = 3'd0;
	logic                has_subs     = 1'b0;
	int                  px           = MAX_X;
	int                  py           = MAX_Y;
	logic [6:0]          shown_col    = 7'(COLS);
	logic [4:0]          shown_row    = 5'(ROWS);

	cursor_report_t      pending_reports [$];
	dir_row_t            dir_tbl [DIR_N];

	int                  cycles    = 0;
	int                  errors    = 0;
	int                  n_sent    = 0;
	int                  n_checked = 0;
	int                  n_drop    = 0;
	int                  n_moved   = 0;
	int                  n_evt     = 0;
	logic                calm      = 1'b0;
	logic                long_hold_req = 1'b0;

	ps2_mouse_text_cursor_tracker_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.pkt_valid       (pkt_valid),
		.pkt_ready       (pkt_ready),
		.status_byte     (status_byte),
		.delta_x_byte    (delta_x_byte),
		.delta_y_byte    (delta_y_byte),
		.wheel_byte      (wheel_byte),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.packet_dropped  (packet_dropped),
		.event_valid     (event_valid),
		.button_bits     (button_bits),
		.wheel_step      (wheel_step),
		.cell_column     (cell_column),
		.cell_line       (cell_line),
		.console_index   (console_index),
		.cursor_moved    (cursor_moved),
		.old_cell_offset (old_cell_offset),
		.new_cell_offset (new_cell_offset)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still pending", cycles,
				pending_reports.size());
			$display("tb_ps2_mouse_text_cursor_tracker_top failed");
			$finish;
		end
	end

	function automatic logic [12:0] cell_offset_of(input int c, input int r);
		return 13'((c + COLS * r) * 2);
	endfunction

	function automatic int clamp_to(input int v, input int hi);
		if (v < 0)
			return 0;
		if (v >= hi)
			return hi;
		return v;
	endfunction

	// Decode one packet against the current registers and advance the cursor.
	// Disabled consoles and overflow packets leave the cursor where it is and
	// report the shown cell unchanged.
	function automatic cursor_report_t track_cursor(input logic [7:0] st, input logic [7:0] dx,
			input logic [7:0] dy, input logic [7:0] wh);
		cursor_report_t r;
		int mx, my, ncol, nrow;
		r = '0;
		r.col = shown_col;
		r.row = shown_row;
		r.cons = view_console;
		r.old_off = cell_offset_of(shown_col, shown_row);
		r.new_off = r.old_off;
		if (!enable_mask[view_console])
			return r;
		if (st[mtt_pkg::STAT_OVF_X] || st[mtt_pkg::STAT_OVF_Y]) begin
			r.dropped = 1'b1;
			return r;
		end
		// Nine-bit deltas; screen Y grows downward, so flip the mouse's Y
		mx = st[mtt_pkg::STAT_SIGN_X] ? int'(dx) - 256 : int'(dx);
		my = st[mtt_pkg::STAT_SIGN_Y] ? 256 - int'(dy) : -int'(dy);
		px = clamp_to(px + mx, MAX_X);
		py = clamp_to(py + my, MAX_Y);
		ncol = px / CELL_PX;
		nrow = py / CELL_PX;
		r.moved = (ncol != int'(shown_col)) || (nrow != int'(shown_row));
		shown_col = 7'(ncol);
		shown_row = 5'(nrow);
		r.btn = st[2:0];
		r.whl = (wh[3:0] == 4'd0) ? mtt_pkg::WHEEL_NONE :
			(wh[3] ? mtt_pkg::WHEEL_DOWN : mtt_pkg::WHEEL_UP);
		r.evt = has_subs && (r.btn != 3'd0 || wh[3:0] != 4'd0);
		r.col = shown_col;
		r.row = shown_row;
		r.new_off = cell_offset_of(ncol, nrow);
		return r;
	endfunction

	// Report with no button or wheel activity, console 0
	function automatic cursor_report_t quiet_report(input logic drp, input logic mv,
			input logic [6:0] c, input logic [4:0] r, input logic [12:0] o, input logic [12:0] n);
		cursor_report_t q;
		q = '0;
		q.dropped = drp;
		q.moved = mv;
		q.col = c;
		q.row = r;
		q.old_off = o;
		q.new_off = n;
		return q;
	endfunction

	// Offer one packet, hold it until the block takes it, then queue the report
	// it must produce. A typed report overrides the predictor's answer, but the
	// predictor still runs so that its cursor follows the block.
	task automatic push_packet(input logic [7:0] st, input logic [7:0] dx, input logic [7:0] dy,
			input logic [7:0] wh, input logic typed, input cursor_report_t want);
		cursor_report_t pred;
		pkt_valid <= 1'b1;
		status_byte <= st;
		delta_x_byte <= dx;
		delta_y_byte <= dy;
		wheel_byte <= wh;
		@(posedge clk);
		while (!pkt_ready)
			@(posedge clk);
		pred = track_cursor(st, dx, dy, wh);
		pending_reports.push_back(typed ? want : pred);
		n_sent++;
	endtask

	// Drop valid for a number of cycles
	task automatic idle_pkt(input int n);
		pkt_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Insert a random sender burst of idle cycles, except in the quiet stretch
	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 7) == 0)
			idle_pkt($urandom_range(1, 6));
	endtask

	// Stop sending and wait until every queued report has come back
	task automatic drain();
		idle_pkt(1);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// Write all three registers back to back over APB; update the predictor's
	// copy at the edge where each write lands
	task automatic write_cfg(input logic [7:0] mask, input logic [2:0] scr, input logic subs);
		mtt_pkg::reg_idx_t regs [3];
		regs = '{mtt_pkg::REG_ENABLE_MASK, mtt_pkg::REG_CURRENT_SCREEN, mtt_pkg::REG_HAS_SUBS};
		foreach (regs[k]) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {regs[k], 2'b00};
			case (regs[k])
				mtt_pkg::REG_ENABLE_MASK:    pwdata <= DATA_W'(mask);
				mtt_pkg::REG_CURRENT_SCREEN: pwdata <= DATA_W'(scr);
				default:                     pwdata <= DATA_W'(subs);
			endcase
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			case (regs[k])
				mtt_pkg::REG_ENABLE_MASK:    enable_mask = mask;
				mtt_pkg::REG_CURRENT_SCREEN: view_console = scr;
				default:                     has_subs = subs;
			endcase
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Result side: ready with random stall bursts, one long hold-off on request,
	// and no stalls at all in the quiet stretch
	initial begin
		logic seen_hold;
		seen_hold = 1'b0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req != seen_hold) begin
				seen_hold = long_hold_req;
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	// Compare every result transfer with the oldest queued report
	always @(posedge clk) begin : check_reports
		cursor_report_t got;
		cursor_report_t want;
		logic [9:0] bad;
		if (arst_n && res_valid && res_ready) begin
			got = {packet_dropped, event_valid, button_bits, wheel_step, cell_column, cell_line,
				console_index, cursor_moved, old_cell_offset, new_cell_offset};
			if (pending_reports.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("report with nothing pending at cycle %0d", cycles);
			end else begin
				want = pending_reports.pop_front();
				n_checked++;
				n_drop += want.dropped;
				n_moved += want.moved;
				n_evt += want.evt;
				bad = {got.dropped !== want.dropped, got.evt !== want.evt,
					got.btn !== want.btn, got.whl !== want.whl,
					got.col !== want.col, got.row !== want.row,
					got.cons !== want.cons, got.moved !== want.moved,
					got.old_off !== want.old_off, got.new_off !== want.new_off};
				if (|bad) begin
					errors++;
					if (errors <= SHOW_MAX) begin
						$display("mismatch on report %0d (fields %b)", n_checked, bad);
						$display("  want drop=%0d evt=%0d btn=%0d whl=%0d ",
							want.dropped, want.evt, want.btn, $signed(want.whl),
							"cell=%0d,%0d con=%0d mv=%0d off=%0d->%0d",
							want.col, want.row, want.cons, want.moved,
							want.old_off, want.new_off);
						$display("  got  drop=%0d evt=%0d btn=%0d whl=%0d ",
							got.dropped, got.evt, got.btn, $signed(got.whl),
							"cell=%0d,%0d con=%0d mv=%0d off=%0d->%0d",
							got.col, got.row, got.cons, got.moved,
							got.old_off, got.new_off);
					end
				end
			end
		end
	end

	initial begin
		logic [7:0] st, dx, dy, wh, mask;
		logic [2:0] scr;
		logic       subs;
		logic [8:0] mv;
		logic [1:0] ovf;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pkt_valid = 1'b0;
		status_byte = 8'h00;
		delta_x_byte = 8'h00;
		delta_y_byte = 8'h00;
		wheel_byte = 8'h00;

		// Directed walk. Reset leaves tracking off, so the first packet only
		// echoes the off-screen cell. Then overflow drops, the first real
		// packet snapping the cursor on screen, full-scale deltas into both
		// clamps, every wheel nibble class, no subscribers, and console 7
		// disabled and enabled.
		dir_tbl[0]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h07, 8'h10, 8'h10, 8'h01,
			1'b1, quiet_report(1'b0, 1'b0, 7'd80, 5'd25, 13'd4160, 13'd4160)};
		dir_tbl[1]  = '{1'b1, 8'hFF, 3'd0, 1'b1, 8'hC0, 8'hFF, 8'hFF, 8'hFF,
			1'b1, quiet_report(1'b1, 1'b0, 7'd80, 5'd25, 13'd4160, 13'd4160)};
		dir_tbl[2]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h40, 8'h01, 8'h80, 8'h00,
			1'b1, quiet_report(1'b1, 1'b0, 7'd80, 5'd25, 13'd4160, 13'd4160)};
		dir_tbl[3]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h80, 8'h00, 8'h00, 8'h0F,
			1'b1, quiet_report(1'b1, 1'b0, 7'd80, 5'd25, 13'd4160, 13'd4160)};
		dir_tbl[4]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00,
			1'b1, quiet_report(1'b0, 1'b1, 7'd79, 5'd24, 13'd4160, 13'd3998)};
		dir_tbl[5]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00,
			1'b1, quiet_report(1'b0, 1'b0, 7'd79, 5'd24, 13'd3998, 13'd3998)};
		dir_tbl[6]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h07, 8'hFF, 8'hFF, 8'h01, 1'b0, '0};
		dir_tbl[7]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h30, 8'h00, 8'h00, 8'h08, 1'b0, '0};
		dir_tbl[8]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h10, 8'h00, 8'h00, 8'h07, 1'b0, '0};
		dir_tbl[9]  = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h10, 8'h00, 8'h00, 8'h0F, 1'b0, '0};
		dir_tbl[10] = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h20, 8'h00, 8'h01, 8'hF0, 1'b0, '0};
		dir_tbl[11] = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h0D, 8'h80, 8'h7F, 8'h80, 1'b0, '0};
		dir_tbl[12] = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h3F, 8'h80, 8'h80, 8'h09, 1'b0, '0};
		dir_tbl[13] = '{1'b1, 8'hFF, 3'd7, 1'b0, 8'h07, 8'h08, 8'hF8, 8'h01, 1'b0, '0};
		dir_tbl[14] = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h02, 8'h00, 8'h00, 8'h0F, 1'b0, '0};
		dir_tbl[15] = '{1'b1, 8'h7F, 3'd7, 1'b1, 8'h05, 8'h20, 8'h20, 8'h01, 1'b0, '0};
		dir_tbl[16] = '{1'b1, 8'h80, 3'd7, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0};
		dir_tbl[17] = '{1'b0, 8'h00, 3'd0, 1'b0, 8'h04, 8'h7F, 8'h00, 8'h02, 1'b0, '0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].reconf) begin
				drain();
				write_cfg(dir_tbl[i].mask, dir_tbl[i].scr, dir_tbl[i].subs);
			end
			push_packet(dir_tbl[i].st, dir_tbl[i].dx, dir_tbl[i].dy, dir_tbl[i].wh,
				dir_tbl[i].typed, dir_tbl[i].want);
			maybe_gap();
		end

		// Random phases, each behind its own register setting. Most phases keep
		// the shown console enabled so packets actually move the cursor; one is
		// fully disabled, and the last runs without any idling.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph == 0) begin
				mask = 8'hFF;
				scr = 3'd0;
				subs = 1'b1;
			end else if (ph == 4) begin
				mask = 8'h00;
				scr = 3'($urandom_range(0, 7));
				subs = 1'b1;
			end else begin
				mask = 8'($urandom());
				scr = 3'($urandom_range(0, 7));
				subs = 1'($urandom_range(0, 1));
				mask[scr] = ($urandom_range(0, 4) != 0);
			end
			write_cfg(mask, scr, subs);
			calm <= (ph == PHASES - 1);
			// Hold off the result side long enough that the pipe backs up
			if (ph == 1)
				long_hold_req <= ~long_hold_req;

			for (int n = 0; n < PHASE_PKTS; n++) begin
				// Mostly small moves so the cursor wanders; some full-scale ones
				if ($urandom_range(0, 3) == 0)
					mv = 9'($urandom_range(0, 511));
				else
					mv = 9'($urandom_range(0, 40) - 20);
				dx = mv[7:0];
				st[mtt_pkg::STAT_SIGN_X] = mv[8];
				if ($urandom_range(0, 3) == 0)
					mv = 9'($urandom_range(0, 511));
				else
					mv = 9'($urandom_range(0, 40) - 20);
				dy = mv[7:0];
				st[mtt_pkg::STAT_SIGN_Y] = mv[8];
				ovf = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
				st[mtt_pkg::STAT_OVF_X] = ovf[0];
				st[mtt_pkg::STAT_OVF_Y] = ovf[1];
				st[3:0] = 4'($urandom());
				wh = 8'($urandom());
				if ($urandom_range(0, 2) == 0)
					wh[3:0] = 4'd0;
				push_packet(st, dx, dy, wh, 1'b0, '0);
				maybe_gap();
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("sent %0d packets, checked %0d reports: ", n_sent, n_checked,
			"%0d overflow drops, %0d cell moves, %0d events", n_drop, n_moved, n_evt);
		$display("%0d mismatches, %0d reports left pending", errors, pending_reports.size());
		if (errors == 0 && pending_reports.size() == 0)
			$display("tb_ps2_mouse_text_cursor_tracker_top passed");
		else
			$display("tb_ps2_mouse_text_cursor_tracker_top failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mtt_pkg.sv
rtl/mtt_cfg_regs.sv
rtl/mtt_pos_stage.sv
rtl/mtt_cell_stage.sv
rtl/mtt_out_stage.sv
rtl/ps2_mouse_text_cursor_tracker_top.sv
tb/tb_ps2_mouse_text_cursor_tracker_top.sv
